FILE: hw/rtl/divisor_sum_classifier_macros.svh
// Assertion macros for the divisor sum classifier.
// Expects signals clk and arst_n in the including scope.
`ifndef DIVISOR_SUM_CLASSIFIER_MACROS_SVH
`define DIVISOR_SUM_CLASSIFIER_MACROS_SVH

// Implication checked in the same cycle.
`define DSC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle.
`define DSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/dsc_pkg.sv
// Shared widths, types and class codes of the divisor sum classifier.
// No dependencies.
package dsc_pkg;

	localparam int VALUE_BITS = 20;
	localparam int SUM_BITS   = VALUE_BITS + 2;
	localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
	localparam int CLASS_BITS = 2;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [SUM_BITS-1:0]   sum_t;
	typedef logic [CLASS_BITS-1:0] class_t;

	localparam class_t CLASS_DEFICIENT = 2'd0;
	localparam class_t CLASS_PERFECT   = 2'd1;
	localparam class_t CLASS_ABUNDANT  = 2'd2;

	typedef struct packed {
		logic   start;
		value_t dividend;
		value_t divisor;
	} div_req_t;

	typedef struct packed {
		logic   done;
		value_t quotient;
		value_t remainder;
	} div_rsp_t;

endpackage

FILE: hw/rtl/dsc_channels.sv
// Valid/ready channels of the divisor sum classifier.
// Depends on dsc_pkg.
interface dsc_item_if;
	logic            valid;
	logic            ready;
	dsc_pkg::value_t number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface

interface dsc_result_if;
	logic            valid;
	logic            ready;
	dsc_pkg::value_t number_echo;
	dsc_pkg::class_t number_class;

	modport source (output valid, output number_echo, output number_class, input ready);
	modport sink   (input valid, input number_echo, input number_class, output ready);
endinterface

FILE: hw/rtl/divisor_sum_classifier.sv
// Channel   | Dir | Payload
// item      | in  | number
// result    | out | number_echo, number_class
//
// Candidates k run from 1 while k <= n/k; each takes one pass of the shared
// divider, then the sequencer steps CHECK, ADD_Q (for a divisor only) and NEXT;
// the search ends early once the sum passes n. Zero skips the divider and goes
// straight to DONE. item.ready is high only while idle; a finished result
// waits in the output register while the next item is taken.
// Reset clears the sequencer and the output valid.
// Depends on dsc_pkg, dsc_channels, dsc_divider and the macros header.
`include "divisor_sum_classifier_macros.svh"

module divisor_sum_classifier (
	input  logic          clk,
	input  logic          arst_n,
	dsc_item_if.sink      item,
	dsc_result_if.source  result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WAIT,
		ST_CHECK,
		ST_ADD_Q,
		ST_NEXT,
		ST_DONE
	} state_t;

	state_t            state_q;
	dsc_pkg::value_t   n_q;
	dsc_pkg::value_t   k_q;
	dsc_pkg::sum_t     sum_q;
	dsc_pkg::class_t   cls_q;
	logic              out_vld_q;
	dsc_pkg::value_t   out_num_q;
	dsc_pkg::class_t   out_cls_q;

	dsc_pkg::div_req_t div_req;
	dsc_pkg::div_rsp_t div_rsp;

	logic              item_xfer;
	logic              over;

	assign item.ready = (state_q == ST_IDLE);
	assign item_xfer  = item.valid && item.ready;
	assign over       = sum_q > dsc_pkg::SUM_BITS'(n_q);

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = n_q;
		div_req.divisor  = k_q + 1'b1;
		if (state_q == ST_IDLE) begin
			div_req.start    = item_xfer && (item.number != '0);
			div_req.dividend = item.number;
			div_req.divisor  = dsc_pkg::VALUE_BITS'(1);
		end else if (state_q == ST_NEXT) begin
			div_req.start = !over;
		end
	end

	dsc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			n_q       <= '0;
			k_q       <= '0;
			sum_q     <= '0;
			cls_q     <= dsc_pkg::CLASS_DEFICIENT;
			out_vld_q <= 1'b0;
			out_num_q <= '0;
			out_cls_q <= dsc_pkg::CLASS_DEFICIENT;
		end else begin
			if (result.valid && result.ready && (state_q != ST_DONE)) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_xfer) begin
						n_q   <= item.number;
						k_q   <= dsc_pkg::VALUE_BITS'(1);
						sum_q <= '0;
						if (item.number == '0) begin
							cls_q   <= dsc_pkg::CLASS_PERFECT;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_WAIT;
						end
					end
				end
				ST_WAIT: begin
					if (div_rsp.done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (k_q > div_rsp.quotient) begin
						cls_q   <= (sum_q == dsc_pkg::SUM_BITS'(n_q)) ?
						           dsc_pkg::CLASS_PERFECT : dsc_pkg::CLASS_DEFICIENT;
						state_q <= ST_DONE;
					end else if (div_rsp.remainder != '0) begin
						state_q <= ST_NEXT;
					end else begin
						if (k_q < n_q) begin
							sum_q <= sum_q + dsc_pkg::SUM_BITS'(k_q);
						end
						state_q <= ST_ADD_Q;
					end
				end
				ST_ADD_Q: begin
					if ((div_rsp.quotient != k_q) && (div_rsp.quotient < n_q)) begin
						sum_q <= sum_q + dsc_pkg::SUM_BITS'(div_rsp.quotient);
					end
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (over) begin
						cls_q   <= dsc_pkg::CLASS_ABUNDANT;
						state_q <= ST_DONE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_WAIT;
					end
				end
				ST_DONE: begin
					if (!out_vld_q || result.ready) begin
						out_vld_q <= 1'b1;
						out_num_q <= n_q;
						out_cls_q <= cls_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid        = out_vld_q;
	assign result.number_echo  = out_num_q;
	assign result.number_class = out_cls_q;

	`DSC_ASSERT_IMP(a_class_legal, result.valid, result.number_class <= dsc_pkg::CLASS_ABUNDANT, "bad class")
	`DSC_ASSERT_IMP(a_sum_bounded, state_q == ST_CHECK, !over, "sum past n before check")
	`DSC_ASSERT_NEXT(a_busy_after_xfer, item_xfer, !item.ready, "ready right after a transfer")
	`DSC_ASSERT_IMP(a_done_in_wait, div_rsp.done, state_q == ST_WAIT, "divider done outside wait")

endmodule

FILE: hw/rtl/dsc_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on dsc_pkg.
module dsc_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  dsc_pkg::div_req_t req,
	output dsc_pkg::div_rsp_t rsp
);

	dsc_pkg::value_t                 quo_q;
	dsc_pkg::value_t                 rem_q;
	dsc_pkg::value_t                 div_q;
	logic [dsc_pkg::CNT_BITS-1:0]    cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [dsc_pkg::VALUE_BITS:0]    trial;
	logic [dsc_pkg::VALUE_BITS:0]    diff;
	logic                            ge;

	assign trial = {rem_q, quo_q[dsc_pkg::VALUE_BITS-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				quo_q  <= req.dividend;
				rem_q  <= '0;
				div_q  <= req.divisor;
				cnt_q  <= dsc_pkg::CNT_BITS'(dsc_pkg::VALUE_BITS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				quo_q <= {quo_q[dsc_pkg::VALUE_BITS-2:0], ge};
				rem_q <= ge ? diff[dsc_pkg::VALUE_BITS-1:0]
				            : trial[dsc_pkg::VALUE_BITS-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == dsc_pkg::CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

FILE: tb/tb.sv
// Testbench for divisor_sum_classifier: drives integers over the item channel and checks
// each echoed number and its deficient/perfect/abundant class against a divisor-sum model.
// Depends on dsc_pkg, dsc_channels and the divisor_sum_classifier RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int DRAIN_CYCLES   = 64;

	typedef struct {
		dsc_pkg::value_t number;
		dsc_pkg::class_t number_class;
	} classified_t;

	logic clk = 1'b0;
	logic arst_n;

	dsc_item_if   item_bus ();
	dsc_result_if result_bus ();

	divisor_sum_classifier uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus)
	);

	classified_t pending_results[$];
	int          mismatch_count = 0;
	int          source_idle_pct = 0;
	int          sink_idle_pct = 0;
	int          quiet_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic dsc_pkg::class_t divisor_class(input dsc_pkg::value_t n);
		longint unsigned v;
		longint unsigned total;
		longint unsigned k;
		longint unsigned q;
		v = n;
		total = 0;
		if (v == 0) begin
			return dsc_pkg::CLASS_PERFECT;
		end
		for (k = 1; k * k <= v; k++) begin
			if (v % k == 0) begin
				q = v / k;
				if (k < v) begin
					total += k;
				end
				if (q != k && q < v) begin
					total += q;
				end
				if (total > v) begin
					return dsc_pkg::CLASS_ABUNDANT;
				end
			end
		end
		return (total == v) ? dsc_pkg::CLASS_PERFECT : dsc_pkg::CLASS_DEFICIENT;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic send_number(input dsc_pkg::value_t n);
		classified_t expected;
		@(negedge clk);
		while ($urandom_range(99) < source_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(negedge clk);
		end
		item_bus.valid  <= 1'b1;
		item_bus.number <= n;
		do @(posedge clk); while (!item_bus.ready);
		expected.number       = n;
		expected.number_class = divisor_class(n);
		pending_results.push_back(expected);
	endtask

	task automatic set_idling(input int source_pct, input int sink_pct);
		source_idle_pct = source_pct;
		sink_idle_pct   = sink_pct;
	endtask

	task automatic test_edge_values();
		send_number(dsc_pkg::value_t'(0));
		send_number(dsc_pkg::value_t'(1));
		send_number(dsc_pkg::value_t'(2));
		send_number(dsc_pkg::value_t'(3));
		send_number(dsc_pkg::value_t'(4));
		send_number(dsc_pkg::value_t'(9));
		send_number(dsc_pkg::value_t'(16));
		send_number(dsc_pkg::value_t'(524288));
		send_number(dsc_pkg::value_t'(1046529));
		send_number(dsc_pkg::value_t'(1048573));
		send_number('1);
	endtask

	task automatic test_perfect_numbers();
		send_number(dsc_pkg::value_t'(6));
		send_number(dsc_pkg::value_t'(28));
		send_number(dsc_pkg::value_t'(496));
		send_number(dsc_pkg::value_t'(8128));
	endtask

	task automatic test_abundant_numbers();
		send_number(dsc_pkg::value_t'(12));
		send_number(dsc_pkg::value_t'(18));
		send_number(dsc_pkg::value_t'(20));
		send_number(dsc_pkg::value_t'(945));
		send_number(dsc_pkg::value_t'(5040));
		send_number(dsc_pkg::value_t'(720720));
	endtask

	task automatic test_random_mix(input int count);
		dsc_pkg::value_t n;
		int              sel;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			if (sel < 5) begin
				n = dsc_pkg::value_t'($urandom);
			end else if (sel < 12) begin
				case ($urandom_range(3))
					0: n = dsc_pkg::value_t'(6);
					1: n = dsc_pkg::value_t'(28);
					2: n = dsc_pkg::value_t'(496);
					default: n = dsc_pkg::value_t'(8128);
				endcase
			end else if (sel < 30) begin
				n = dsc_pkg::value_t'($urandom_range(340, 1) * 12);
			end else if (sel < 50) begin
				n = dsc_pkg::value_t'($urandom_range(255, 1));
			end else begin
				n = dsc_pkg::value_t'($urandom_range(4095, 1));
			end
			send_number(n);
		end
	endtask

	always @(negedge clk) begin
		result_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		classified_t expected;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result for %0d", result_bus.number_echo));
			end else begin
				expected = pending_results.pop_front();
				if (result_bus.number_echo !== expected.number) begin
					report_mismatch($sformatf("number_echo %0d, expected %0d",
						result_bus.number_echo, expected.number));
				end
				if (result_bus.number_class !== expected.number_class) begin
					report_mismatch($sformatf("number_class %0d for %0d, expected %0d",
						result_bus.number_class, expected.number, expected.number_class));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_bus.valid && item_bus.ready)
				|| (result_bus.valid && result_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n           = 1'b0;
		item_bus.valid   = 1'b0;
		item_bus.number  = '0;
		result_bus.ready = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		set_idling(27, 50);
		test_edge_values();
		test_perfect_numbers();
		test_abundant_numbers();
		test_random_mix(35);

		set_idling(50, 27);
		test_random_mix(35);

		set_idling(0, 0);
		test_random_mix(30);

		@(negedge clk);
		item_bus.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/dsc_pkg.sv
hw/rtl/dsc_channels.sv
hw/rtl/dsc_divider.sv
hw/rtl/divisor_sum_classifier.sv
tb/tb.sv
